// ===== design/btpc_pkg.sv =====
// Shared types, constants and helpers for the barometer compensation pipeline.
package btpc_pkg;

  localparam int unsigned DivW = 32;

  localparam logic [2:0] CfgAc123 = 3'd0;
  localparam logic [2:0] CfgAc456 = 3'd1;
  localparam logic [2:0] CfgB1B2  = 3'd2;
  localparam logic [2:0] CfgMcMd  = 3'd3;
  localparam logic [2:0] CfgOss   = 3'd4;

  localparam logic signed [31:0] B6Offset  = 32'sd4000;
  localparam logic signed [31:0] PCoefSq   = 32'sd3038;
  localparam logic signed [31:0] PCoefLin  = -32'sd7357;
  localparam logic signed [31:0] PCoefOff  = 32'sd3791;
  localparam logic [31:0]        B7Scale   = 32'd50000;
  localparam logic signed [31:0] B4Bias    = 32'sd32768;

  typedef struct packed {
    logic signed [31:0] x1;
    logic [23:0]        up;
    logic               neg;
    logic               err;
  } d1_side_t;

  typedef struct packed {
    logic signed [31:0] b5;
    logic               big;
    logic               err;
  } d2_side_t;

  // signed divide by 2**k, truncating toward zero
  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] a,
                                                 input int unsigned k);
    logic signed [31:0] bias;
    bias = a[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
    return (a + bias) >>> k;
  endfunction

endpackage

// ===== design/btpc_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
module btpc_div import btpc_pkg::*; #(
  parameter int unsigned SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [DivW-1:0] quot_o,
  output logic [SW-1:0]   side_o
);

  logic [DivW-1:0] v_q;
  logic [DivW-1:0] rem_q  [DivW];
  logic [DivW-1:0] acc_q  [DivW];
  logic [DivW-1:0] dvs_q  [DivW];
  logic [SW-1:0]   side_q [DivW];

  for (genvar k = 0; k < DivW; k++) begin : g_stage
    logic            s_v;
    logic [DivW-1:0] s_rem;
    logic [DivW-1:0] s_acc;
    logic [DivW-1:0] s_dvs;
    logic [SW-1:0]   s_side;
    logic [DivW:0]   sh;
    logic [DivW:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign s_v    = valid_i;
      assign s_rem  = '0;
      assign s_acc  = dividend_i;
      assign s_dvs  = divisor_i;
      assign s_side = side_i;
    end else begin : g_next
      assign s_v    = v_q[k-1];
      assign s_rem  = rem_q[k-1];
      assign s_acc  = acc_q[k-1];
      assign s_dvs  = dvs_q[k-1];
      assign s_side = side_q[k-1];
    end

    assign sh   = {s_rem, s_acc[DivW-1]};
    assign diff = sh - {1'b0, s_dvs};
    assign ge   = ~diff[DivW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= s_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DivW-1:0] : sh[DivW-1:0];
        acc_q[k]  <= {s_acc[DivW-2:0], ge};
        dvs_q[k]  <= s_dvs;
        side_q[k] <= s_side;
      end
    end
  end

  assign valid_o = v_q[DivW-1];
  assign quot_o  = acc_q[DivW-1];
  assign side_o  = side_q[DivW-1];

endmodule

// ===== design/baro_temp_pressure_compensate_unit.sv =====
// One request per cycle is accepted while the output register is empty or taken.
// The pipeline holds two 32-stage divider pipelines (temperature, pressure) plus ten other stages.
// The whole pipeline advances when the output register is empty or taken.
// Reset clears all valid bits and calibration registers to zero.
// Top level of the barometer integer temperature/pressure compensation.
module baro_temp_pressure_compensate_unit import btpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [47:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        raw_temp_i,
  input  logic [23:0]        raw_press_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] temperature_x160_o,
  output logic signed [31:0] pressure_pa_o,
  output logic               div_error_o
);

  logic [47:0] cal0_q, cal1_q;
  logic [31:0] cal2_q, cal3_q;
  logic [1:0]  oss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal0_q <= '0;
      cal1_q <= '0;
      cal2_q <= '0;
      cal3_q <= '0;
      oss_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAc123: cal0_q <= cfg_data_i;
        CfgAc456: cal1_q <= cfg_data_i;
        CfgB1B2:  cal2_q <= cfg_data_i[31:0];
        CfgMcMd:  cal3_q <= cfg_data_i[31:0];
        CfgOss:   oss_q  <= cfg_data_i[1:0];
        default:  ;
      endcase
    end
  end

  logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = {{16{cal0_q[15]}}, cal0_q[15:0]};
  assign ac2 = {{16{cal0_q[31]}}, cal0_q[31:16]};
  assign ac3 = {{16{cal0_q[47]}}, cal0_q[47:32]};
  assign ac4 = {16'd0, cal1_q[15:0]};
  assign ac5 = {16'd0, cal1_q[31:16]};
  assign ac6 = {16'd0, cal1_q[47:32]};
  assign b1  = {{16{cal2_q[15]}}, cal2_q[15:0]};
  assign b2  = {{16{cal2_q[31]}}, cal2_q[31:16]};
  assign mc  = {{16{cal3_q[15]}}, cal3_q[15:0]};
  assign md  = {{16{cal3_q[31]}}, cal3_q[31:16]};

  logic en;
  logic out_v_q;
  assign en         = ~out_v_q | out_ready_i;
  assign in_ready_o = en;

  // stage 1: temperature product
  logic               v1_q;
  logic signed [31:0] x1a_q;
  logic [23:0]        up1_q;
  logic signed [31:0] ut;
  assign ut = {16'd0, raw_temp_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1a_q <= (ut - ac6) * ac5;
      up1_q <= 24'(raw_press_i >> (4'd8 - {2'd0, oss_q}));
    end
  end

  // temperature divide
  logic signed [31:0] t_x1, t_den, t_num;
  d1_side_t           d1_in, d1_out;
  logic               d1_v;
  logic [31:0]        d1_q;
  assign t_x1  = sdiv_p2(x1a_q, 15);
  assign t_den = t_x1 + md;
  assign t_num = mc <<< 11;
  assign d1_in = '{x1: t_x1, up: up1_q, neg: t_num[31] ^ t_den[31], err: (t_den == 32'sd0)};

  btpc_div #(.SW($bits(d1_side_t))) u_div_t (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q),
    .dividend_i(t_num[31] ? -t_num : t_num),
    .divisor_i(t_den[31] ? -t_den : t_den),
    .side_i(d1_in), .valid_o(d1_v), .quot_o(d1_q), .side_o(d1_out)
  );

  // stages A..E
  logic               va_q, vb_q, vc_q, vd_q, ve_q;
  logic signed [31:0] b5a_q, b5b_q, b5c_q, b5d_q, b5e_q;
  logic [23:0]        upa_q, upb_q, upc_q, upd_q;
  logic               erra_q, errb_q, errc_q, errd_q, erre_q;
  logic signed [31:0] bb_q, mac2b_q, mac3b_q;
  logic signed [31:0] mb1_q, mb2_q, mac2c_q, mac3c_q;
  logic signed [31:0] b3_q, tb4_q;
  logic [31:0]        b4_q, b7_q;

  logic signed [31:0] x2a, b6, sq;
  logic signed [31:0] dx1, dx2, dx3, b3u, px1, px2, px3;
  logic [31:0]        b4p;
  assign x2a = d1_out.neg ? -$signed(d1_q) : $signed(d1_q);
  assign b6  = b5a_q - B6Offset;
  assign sq  = sdiv_p2(bb_q, 12);
  assign dx1 = sdiv_p2(mb2_q, 11);
  assign dx2 = sdiv_p2(mac2c_q, 11);
  assign dx3 = dx1 + dx2;
  assign b3u = ((ac1 <<< 2) + dx3) << oss_q;
  assign px1 = sdiv_p2(mac3c_q, 13);
  assign px2 = sdiv_p2(mb1_q, 16);
  assign px3 = sdiv_p2(px1 + px2 + 32'sd2, 2);
  assign b4p = ac4 * tb4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; vc_q <= 1'b0; vd_q <= 1'b0; ve_q <= 1'b0;
    end else if (en) begin
      va_q <= d1_v; vb_q <= va_q; vc_q <= vb_q; vd_q <= vc_q; ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b5a_q   <= d1_out.x1 + x2a;
      upa_q   <= d1_out.up;
      erra_q  <= d1_out.err;
      bb_q    <= b6 * b6;
      mac2b_q <= ac2 * b6;
      mac3b_q <= ac3 * b6;
      b5b_q   <= b5a_q;
      upb_q   <= upa_q;
      errb_q  <= erra_q;
      mb2_q   <= b2 * sq;
      mb1_q   <= b1 * sq;
      mac2c_q <= mac2b_q;
      mac3c_q <= mac3b_q;
      b5c_q   <= b5b_q;
      upc_q   <= upb_q;
      errc_q  <= errb_q;
      b3_q    <= sdiv_p2(b3u + 32'sd2, 2);
      tb4_q   <= px3 + B4Bias;
      b5d_q   <= b5c_q;
      upd_q   <= upc_q;
      errd_q  <= errc_q;
      b4_q    <= {15'd0, b4p[31:15]};
      b7_q    <= ({8'd0, upd_q} - b3_q) * (B7Scale >> oss_q);
      b5e_q   <= b5d_q;
      erre_q  <= errd_q;
    end
  end

  // pressure divide
  d2_side_t    d2_in, d2_out;
  logic        d2_v;
  logic [31:0] d2_q;
  assign d2_in = '{b5: b5e_q, big: b7_q[31], err: erre_q | (b4_q == 32'd0)};

  btpc_div #(.SW($bits(d2_side_t))) u_div_p (
    .clk_i, .rst_ni, .en_i(en), .valid_i(ve_q),
    .dividend_i(b7_q[31] ? b7_q : {b7_q[30:0], 1'b0}),
    .divisor_i(b4_q),
    .side_i(d2_in), .valid_o(d2_v), .quot_o(d2_q), .side_o(d2_out)
  );

  // stages F..H and output
  logic               vf_q, vg_q, vh_q;
  logic signed [31:0] pf_q, pg_q, ph_q, b5f_q, b5g_q, b5h_q;
  logic               errf_q, errg_q, errh_q;
  logic signed [31:0] sqp_q, m2g_q, m2h_q, m1_q;
  logic signed [31:0] ps, ox1, ox2, pres;
  logic signed [31:0] temp_q, pres_q;
  logic               err_q;

  assign ps   = sdiv_p2(pf_q, 8);
  assign ox1  = sdiv_p2(m1_q, 16);
  assign ox2  = sdiv_p2(m2h_q, 16);
  assign pres = ph_q + sdiv_p2(ox1 + ox2 + PCoefOff, 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0; vg_q <= 1'b0; vh_q <= 1'b0; out_v_q <= 1'b0;
    end else if (en) begin
      vf_q <= d2_v; vg_q <= vf_q; vh_q <= vg_q; out_v_q <= vh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pf_q   <= d2_out.big ? $signed({d2_q[30:0], 1'b0}) : $signed(d2_q);
      b5f_q  <= d2_out.b5;
      errf_q <= d2_out.err;
      sqp_q  <= ps * ps;
      m2g_q  <= PCoefLin * pf_q;
      pg_q   <= pf_q;
      b5g_q  <= b5f_q;
      errg_q <= errf_q;
      m1_q   <= sqp_q * PCoefSq;
      m2h_q  <= m2g_q;
      ph_q   <= pg_q;
      b5h_q  <= b5g_q;
      errh_q <= errg_q;
      temp_q <= errh_q ? 32'sd0 : b5h_q + 32'sd8;
      pres_q <= errh_q ? 32'sd0 : pres;
      err_q  <= errh_q;
    end
  end

  assign out_valid_o        = out_v_q;
  assign temperature_x160_o = temp_q;
  assign pressure_pa_o      = pres_q;
  assign div_error_o        = err_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_error_o |-> temperature_x160_o == 32'sd0 && pressure_pa_o == 32'sd0)
    else $error("error result not zeroed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("ready does not follow output register");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(pressure_pa_o) && $stable(div_error_o))
    else $error("stalled result changed");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the barometer temperature/pressure compensation unit.
module testbench;
  import btpc_pkg::*;

  typedef struct {
    logic [15:0] ut;
    logic [23:0] rp;
  } meas_t;

  typedef struct {
    logic signed [31:0] temp;
    logic signed [31:0] pres;
    logic               err;
  } comp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [15:0] raw_temp_i = '0;
  logic [23:0] raw_press_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] temperature_x160_o, pressure_pa_o;
  logic div_error_o;

  baro_temp_pressure_compensate_unit u_top (.*);

  always #10 clk_i = ~clk_i;

  logic [47:0] k_ac123, k_ac456;
  logic [31:0] k_b12, k_mcmd;
  logic [1:0]  k_oss;

  meas_t meas_q[$];
  comp_t comp_q[$];
  int send_idle_pct = 22, recv_idle_pct = 67;
  bit hold_send = 0;
  int fail_cnt = 0;
  int quiet_cycles = 0;

  function automatic logic signed [31:0] tdiv(logic signed [31:0] a, logic signed [31:0] b);
    if (a == 32'sh80000000 && b == -32'sd1) return a;
    return a / b;
  endfunction

  function automatic logic signed [31:0] s16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic comp_t compensate(meas_t m);
    comp_t r;
    logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic signed [31:0] x1, x2, x3, b3, b5, b6, sq, p, den;
    logic [31:0] up, b4, b7, b3u;
    ac1 = s16(k_ac123[15:0]); ac2 = s16(k_ac123[31:16]); ac3 = s16(k_ac123[47:32]);
    ac4 = {16'd0, k_ac456[15:0]}; ac5 = {16'd0, k_ac456[31:16]};
    ac6 = {16'd0, k_ac456[47:32]};
    b1 = s16(k_b12[15:0]); b2 = s16(k_b12[31:16]);
    mc = s16(k_mcmd[15:0]); md = s16(k_mcmd[31:16]);
    up = {8'd0, m.rp} >> (8 - k_oss);
    r = '{temp: 0, pres: 0, err: 1'b1};
    x1 = tdiv(({16'd0, m.ut} - ac6) * ac5, 32768);
    den = x1 + md;
    if (den == 0) return r;
    x2 = tdiv(mc * 2048, den);
    b5 = x1 + x2;
    b6 = b5 - 4000;
    sq = tdiv(b6 * b6, 4096);
    x1 = tdiv(b2 * sq, 2048);
    x2 = tdiv(ac2 * b6, 2048);
    x3 = x1 + x2;
    b3u = 32'(ac1 * 4 + x3) << k_oss;
    b3 = tdiv(b3u + 2, 4);
    x1 = tdiv(ac3 * b6, 8192);
    x2 = tdiv(b1 * sq, 65536);
    x3 = tdiv(x1 + x2 + 2, 4);
    b4 = (32'(ac4) * 32'(x3 + 32768)) / 32'd32768;
    if (b4 == 0) return r;
    b7 = (up - 32'(b3)) * (32'd50000 >> k_oss);
    if (b7 < 32'h80000000) p = (b7 * 2) / b4;
    else p = (b7 / b4) * 2;
    x1 = tdiv(p, 256) * tdiv(p, 256);
    x1 = tdiv(x1 * 3038, 65536);
    x2 = tdiv(-32'sd7357 * p, 65536);
    r.temp = b5 + 8;
    r.pres = p + tdiv(x1 + x2 + 3791, 16);
    r.err = 1'b0;
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      comp_q.push_back(compensate(meas_q.pop_front()));
    end
    if (!(in_valid_i && !in_ready_o)) begin
      if (meas_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        raw_temp_i <= meas_q[0].ut;
        raw_press_i <= meas_q[0].rp;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    comp_t e;
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (out_valid_o && out_ready_i) begin
      if (comp_q.size() == 0) begin
        $display("%0t unexpected result temp=%0d pres=%0d err=%0b", $time,
                 temperature_x160_o, pressure_pa_o, div_error_o);
        fail_cnt++;
      end else begin
        e = comp_q.pop_front();
        if (e.temp !== temperature_x160_o || e.pres !== pressure_pa_o ||
            e.err !== div_error_o) begin
          $display("%0t mismatch exp temp=%0d pres=%0d err=%0b act temp=%0d pres=%0d err=%0b",
                   $time, e.temp, e.pres, e.err, temperature_x160_o, pressure_pa_o,
                   div_error_o);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgAc123: k_ac123 = val;
      CfgAc456: k_ac456 = val;
      CfgB1B2:  k_b12 = val[31:0];
      CfgMcMd:  k_mcmd = val[31:0];
      CfgOss:   k_oss = val[1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (meas_q.size() > 0 || comp_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // sensor coefficients: typical (mode 0), random (mode 1), all ones (mode 2) or extreme values
  task automatic load_cal(int mode);
    logic [47:0] a, b;
    logic [31:0] c, d;
    if (mode == 0) begin
      a = {16'hC7B2, 16'hFB8B, 16'h1A88}; // AC3=-14414, AC2=-1141, AC1=6792
      b = {16'd23470, 16'd24948, 16'd33625};
      c = {16'd44, 16'd6515};
      d = {16'd2926, -16'sd11786};
    end else if (mode == 1) begin
      a = {$urandom, $urandom}; b = {$urandom, $urandom};
      c = $urandom; d = $urandom;
    end else if (mode == 2) begin
      a = '1; b = '1; c = '1; d = '1;
    end else begin
      a = {16'h8000, 16'h8000, 16'h8000}; b = {16'hFFFF, 16'hFFFF, 16'h0001};
      c = 32'h80008000; d = 32'h7FFF8000;
    end
    write_reg(CfgAc123, a);
    write_reg(CfgAc456, b);
    write_reg(CfgB1B2, {16'd0, c});
    write_reg(CfgMcMd, {16'd0, d});
  endtask

  task automatic add_random(int n);
    meas_t m;
    repeat (n) begin
      if ($urandom_range(3) != 0) begin
        m.ut = 16'($urandom_range(20000, 35000));
        m.rp = 24'($urandom_range(24'h500000, 24'hB00000));
      end else begin
        m.ut = 16'($urandom);
        m.rp = 24'($urandom);
      end
      meas_q.push_back(m);
    end
  endtask

  initial begin
    k_ac123 = '0; k_ac456 = '0; k_b12 = '0; k_mcmd = '0; k_oss = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // all-zero calibration: divisor is zero
    meas_q.push_back('{16'h0000, 24'h000000});
    meas_q.push_back('{16'hFFFF, 24'hFFFFFF});
    drain();
    load_cal(0);
    write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 16; i++) meas_q.push_back('{16'(1 << i), 24'h5D23F0});
    meas_q.push_back('{16'd27898, 24'h5D23F0});
    meas_q.push_back('{16'hFFFF, 24'hFFFFFF});
    meas_q.push_back('{16'h0000, 24'h000000});
    meas_q.push_back('{16'h5555, 24'hAAAAAA});
    drain();
    // MD cancels X1: temperature divisor zero
    write_reg(CfgMcMd, {16'd0, 16'hFFFC, 16'd100});
    write_reg(CfgAc456, {16'd1, 16'd32768, 16'd1});
    meas_q.push_back('{16'd5, 24'h123456});
    drain();
    // AC4 zero: pressure divisor zero
    write_reg(CfgAc456, {16'd23470, 16'd24948, 16'd0});
    write_reg(CfgMcMd, {16'd0, 16'd2926, -16'sd11786});
    meas_q.push_back('{16'd27898, 24'h5D23F0});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 22; recv_idle_pct = 67; end
        1: begin send_idle_pct = 67; recv_idle_pct = 22; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      load_cal(ph == 2 ? 2 : ph == 5 ? 3 : ph % 2);
      write_reg(CfgOss, 48'(ph % 4));
      add_random(70);
      if (ph == 4) begin
        repeat (30) @(posedge clk_i);
        hold_send = 1;
        while (comp_q.size() > 0) @(posedge clk_i);
        hold_send = 0;
      end
      drain();
    end

    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
design/btpc_pkg.sv
design/btpc_div.sv
design/baro_temp_pressure_compensate_unit.sv
tb/testbench.sv
